FILE: src/sesc_pkg.sv
// Shared types, codes and constants for the string escaper.
// No dependencies; every other file in src imports this package.
package sesc_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       text_end;
   } rsp_word_type;

   // How one slot of a job is written out
   localparam logic [1:0] KIND_RAW = 2'd0;   // byte as is
   localparam logic [1:0] KIND_ESC = 2'd1;   // backslash, then the stored letter
   localparam logic [1:0] KIND_HEX = 2'd2;   // \xHH

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } slot_type;

   localparam int JOB_SLOTS = 4;

   typedef struct packed {
      slot_type [JOB_SLOTS-1:0] slots;
      logic [1:0]               last_slot;
      logic                     last;
   } job_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_BSL  = 8'h5C;
   localparam logic [7:0] CHAR_T    = 8'h74;
   localparam logic [7:0] CHAR_N    = 8'h6E;
   localparam logic [7:0] CHAR_R    = 8'h72;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_HEXA = 8'h37;   // 'A' - 10

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'h0, nib};
      if (nib < 4'd10) begin
         hex_digit = CHAR_ZERO + wide;
      end else begin
         hex_digit = CHAR_HEXA + wide;
      end
   endfunction

endpackage

FILE: src/sesc_front.sv
// Front end: tracks the open UTF-8 sequence and turns input bytes into jobs of
// up to four output slots; held sequence bytes push none. Depends on sesc_pkg.
module sesc_front
   import sesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_word_type req_word,
   output logic         push_valid,
   output job_type      push_job
);

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_cnt_ff, held_cnt_in;
   logic [2:0] seq_len_ff, seq_len_in;

   logic [7:0] b;
   logic       last;
   logic       open_seq, is_cont, complete, extend;
   logic [2:0] lead_len;
   logic [1:0] n_held;
   logic [1:0] held_kind;
   logic [1:0] tail_kind;
   logic [7:0] tail_data;
   logic       tail_present;
   logic       hold_lead;
   logic [2:0] total;

   assign b    = req_word.in_byte;
   assign last = req_word.string_end;

   assign open_seq = (held_cnt_ff != 2'd0) && (seq_len_ff > {1'b0, held_cnt_ff});
   assign is_cont  = (b[7:6] == 2'b10);
   assign complete = open_seq && is_cont && (({1'b0, held_cnt_ff} + 3'd1) == seq_len_ff);
   assign extend   = open_seq && is_cont && !complete;
   assign n_held   = open_seq ? held_cnt_ff : 2'd0;
   assign held_kind = complete ? KIND_RAW : KIND_HEX;

   always_comb begin
      if (b[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   // last slot of the job: the arriving byte, escaped or raw
   always_comb begin
      tail_kind    = KIND_RAW;
      tail_data    = b;
      tail_present = 1'b1;
      hold_lead    = 1'b0;
      if (complete) begin
         tail_kind = KIND_RAW;
      end else if (extend) begin
         tail_kind    = KIND_HEX;
         tail_present = last;
      end else begin
         case (b)
            CHAR_TAB: begin tail_kind = KIND_ESC; tail_data = CHAR_T;   end
            CHAR_BSL: begin tail_kind = KIND_ESC; tail_data = CHAR_BSL; end
            CHAR_LF:  begin tail_kind = KIND_ESC; tail_data = CHAR_N;   end
            CHAR_CR:  begin tail_kind = KIND_ESC; tail_data = CHAR_R;   end
            default: begin
               if (!b[7]) begin
                  tail_kind = KIND_RAW;
               end else if (lead_len == 3'd0 || last) begin
                  tail_kind = KIND_HEX;
               end else begin
                  tail_present = 1'b0;
                  hold_lead    = 1'b1;
               end
            end
         endcase
      end
   end

   assign total = {1'b0, n_held} + {2'b00, tail_present};

   always_comb begin
      for (int i = 0; i < JOB_SLOTS - 1; i++) begin
         if (2'(i) < n_held) begin
            push_job.slots[i].kind = held_kind;
            push_job.slots[i].data = held_ff[i];
         end else begin
            push_job.slots[i].kind = tail_kind;
            push_job.slots[i].data = tail_data;
         end
      end
      push_job.slots[JOB_SLOTS-1].kind = tail_kind;
      push_job.slots[JOB_SLOTS-1].data = tail_data;
      push_job.last_slot = 2'(total - 3'd1);
      push_job.last      = last;
   end

   // a continuation that only extends the sequence emits nothing
   assign push_valid = accept && !(extend && !last) && (total != 3'd0);

   always_comb begin
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      if (accept) begin
         if (extend) begin
            held_in[held_cnt_ff] = b;
            held_cnt_in          = held_cnt_ff + 2'd1;
         end else begin
            held_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
            if (hold_lead) begin
               held_in[0]  = b;
               held_cnt_in = 2'd1;
               seq_len_in  = lead_len;
            end
         end
         if (last) begin
            held_cnt_in = 2'd0;
            seq_len_in  = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '{default: 8'h00};
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
      end else begin
         held_ff     <= held_in;
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
      end
   end

endmodule

FILE: src/sesc_queue.sv
// Two-entry job queue between front and back end.
// Depends on sesc_pkg.
module sesc_queue
   import sesc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   job_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  cnt_ff, cnt_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + QUEUE_PTR_W'(1);
      end
   endfunction

   assign full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: src/sesc_back.sv
// Back end: walks the head job slot by slot and writes one escaped
// byte per cycle, unless stalled, into the output register. Depends on sesc_pkg.
module sesc_back
   import sesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         empty,
   input  job_type      head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic [1:0]   slot_idx_ff, slot_idx_in;
   logic [1:0]   char_idx_ff, char_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   slot_type   cur;
   logic [7:0] ch;
   logic       slot_done;
   logic       job_done;
   logic       out_free;
   logic       advance;

   assign cur = head.slots[slot_idx_ff];

   always_comb begin
      ch        = cur.data;
      slot_done = 1'b1;
      unique case (cur.kind)
         KIND_RAW: begin
            ch        = cur.data;
            slot_done = 1'b1;
         end
         KIND_ESC: begin
            ch        = (char_idx_ff == 2'd0) ? CHAR_BSL : cur.data;
            slot_done = (char_idx_ff == 2'd1);
         end
         KIND_HEX: begin
            case (char_idx_ff)
               2'd0:    ch = CHAR_BSL;
               2'd1:    ch = CHAR_X;
               2'd2:    ch = hex_digit(cur.data[7:4]);
               default: ch = hex_digit(cur.data[3:0]);
            endcase
            slot_done = (char_idx_ff == 2'd3);
         end
         default: begin
            ch        = cur.data;
            slot_done = 1'b1;
         end
      endcase
   end

   assign job_done = slot_done && (slot_idx_ff == head.last_slot);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = !empty && out_free;
   assign pop      = advance && job_done;

   always_comb begin
      slot_idx_in  = slot_idx_ff;
      char_idx_in  = char_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.out_byte = ch;
         rsp_word_in.run_end  = job_done;
         rsp_word_in.text_end = job_done && head.last;
         if (slot_done) begin
            char_idx_in = 2'd0;
            slot_idx_in = job_done ? 2'd0 : slot_idx_ff + 2'd1;
         end else begin
            char_idx_in = char_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_idx_ff  <= 2'd0;
         char_idx_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_idx_ff  <= slot_idx_in;
         char_idx_ff  <= char_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_raw_one_char: assert property (@(posedge clock) disable iff (reset)
      (!empty && cur.kind == KIND_RAW) |-> (char_idx_ff == 2'd0))
      else $error("raw slot walked past its only byte");

   a_slot_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (slot_idx_ff <= head.last_slot))
      else $error("slot index beyond the job");

   a_idle_indices: assert property (@(posedge clock) disable iff (reset)
      empty |-> (slot_idx_ff == 2'd0 && char_idx_ff == 2'd0))
      else $error("walk indices not cleared between jobs");

   a_text_end_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.text_end) |-> rsp_word_ff.run_end)
      else $error("string end flagged on a byte that does not close its run");
`endif

endmodule

FILE: src/string_escape_utf8_passthrough.sv
// C-style string escaper with UTF-8 passthrough, top level.
// Depends on sesc_pkg, sesc_front, sesc_queue and sesc_back.
//
// Use:
//   req_ channel: one raw string byte per word (in_byte) plus string_end
//   on the last byte of the string. A word is taken when req_valid is
//   high and req_stall low.
//   rsp_ channel: one escaped byte per word. run_end marks the last byte
//   caused by an input word, text_end the last byte of the whole string.
//   Bytes of an unfinished UTF-8 sequence produce nothing until the
//   sequence completes, breaks or the string ends.
// Timing:
//   The first output byte of an input word passes through the job
//   queue and the output register before it shows on rsp_word.
//   Output runs at one byte per cycle while rsp_stall is low. An input
//   word yields 1 byte for plain text, 2 for \t \\ \n \r, 4 per \xHH
//   escape, up to 16 when a broken sequence is flushed. The output
//   register sets the rate.
//   The front end takes a new word every cycle while the two-entry job
//   queue has room; req_stall is simply "queue full".
// Reset: clears the held sequence, the queue and the output valid flag.
// Stall: when rsp_stall is high the output word holds; the back end
//   stops, the queue fills, and then req_stall rises.
module string_escape_utf8_passthrough
   import sesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic    accept;
   logic    push_valid;
   job_type push_job;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   job_type q_head;

   // front may only take a word when the queue can absorb its job
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   sesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   sesc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // back end expands one slot character per cycle into rsp_word unless stalled
   sesc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
